>>> design/pbc_pkg.sv
// Shared types, constants and helpers for the periodic box cell mapper.
`timescale 1ns / 1ps

package pbc_pkg;

  // Coordinate and field widths
  localparam int CW        = 32;                       // signed Q16.16 coordinate
  localparam int MAX_CELLS = 1024;                     // cells per axis, upper limit
  localparam int CELL_W    = 10;                       // cell coordinate field
  localparam int IDX_W     = 20;                       // flat cell index field
  localparam int SIZE_W    = 31;                       // cell_size register
  localparam int CNT_W     = 11;                       // cells_y register
  localparam int QB        = $clog2(MAX_CELLS) + 1;    // quotient bits, holds MAX_CELLS
  localparam int RW        = SIZE_W + QB;              // divider remainder width
  localparam int XW        = CW + 4;                   // widened coordinate math
  localparam int PW        = RW + 2;                   // signed compare against size << QB

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [QB-1:0] MAX_Q = QB'(MAX_CELLS);

  typedef enum logic [1:0] {
    MODE_WRAP  = 2'd0,
    MODE_BRING = 2'd1,
    MODE_CELL  = 2'd2,
    MODE_PASS  = 2'd3
  } mode_t;

  typedef enum logic [CFG_AW-1:0] {
    CFG_BOX_LO_X  = 3'd0,
    CFG_BOX_LO_Y  = 3'd1,
    CFG_BOX_HI_X  = 3'd2,
    CFG_BOX_HI_Y  = 3'd3,
    CFG_CELL_SIZE = 3'd4,
    CFG_PERIODIC_X = 3'd5,
    CFG_PERIODIC_Y = 3'd6,
    CFG_CELLS_Y   = 3'd7
  } cfg_idx_t;

  // Configuration register set
  typedef struct packed {
    logic signed [CW-1:0] box_lo_x;
    logic signed [CW-1:0] box_lo_y;
    logic signed [CW-1:0] box_hi_x;
    logic signed [CW-1:0] box_hi_y;
    logic [SIZE_W-1:0]    cell_size;
    logic                 periodic_x;
    logic                 periodic_y;
    logic [CNT_W-1:0]     cells_y;
  } cfg_t;

  // Request payload
  typedef struct packed {
    mode_t                mode;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] moved_x;
    logic signed [CW-1:0] moved_y;
    logic                 last_in;
  } req_t;

  // Result payload
  typedef struct packed {
    logic signed [CW-1:0] res_x;
    logic signed [CW-1:0] res_y;
    logic [CELL_W-1:0]    cell_col;
    logic [CELL_W-1:0]    cell_row;
    logic [IDX_W-1:0]     cell_index;
    logic                 out_of_grid;
    logic                 last_out;
  } rsp_t;

  // Image stage to divider stage
  typedef struct packed {
    logic                 is_cell;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic signed [CW-1:0] res_x;
    logic signed [CW-1:0] res_y;
    logic                 last;
  } img_t;

  // Divider stage to grid stage
  typedef struct packed {
    logic                 is_cell;
    logic signed [CW-1:0] res_x;
    logic signed [CW-1:0] res_y;
    logic                 last;
    logic                 col_neg;
    logic                 row_neg;
    logic                 col_big;
    logic                 row_big;
    logic [QB-1:0]        col_q;
    logic [QB-1:0]        row_q;
    logic [QB-1:0]        nx_q;
    logic                 nx_big;
    logic                 nx_zero;
  } div_t;

  // Sign extend a coordinate into the wide math format
  function automatic logic signed [XW-1:0] sx(input logic signed [CW-1:0] v);
    return XW'(v);
  endfunction

  // Absolute value, wide values never reach the most negative code
  function automatic logic signed [XW-1:0] mag(input logic signed [XW-1:0] v);
    return v[XW-1] ? -v : v;
  endfunction

  // Clip a wide value into the coordinate range
  function automatic logic signed [CW-1:0] sat(input logic signed [XW-1:0] v);
    logic fits;
    fits = (&v[XW-1:CW-1]) || !(|v[XW-1:CW-1]);
    if (fits) begin
      return v[CW-1:0];
    end else if (v[XW-1]) begin
      return {1'b1, {(CW-1){1'b0}}};
    end else begin
      return {1'b0, {(CW-1){1'b1}}};
    end
  endfunction

endpackage

>>> design/pbc_image.sv
// Wrap and minimum-image pipeline: five stages, one request per cycle while dn_ready is high.
`timescale 1ns / 1ps

module pbc_image (
  input  logic          clk,
  input  logic          rst,
  input  pbc_pkg::cfg_t cfg,
  input  logic          up_valid,
  output logic          up_ready,
  input  pbc_pkg::req_t up_data,
  output logic          dn_valid,
  input  logic          dn_ready,
  output pbc_pkg::img_t dn_data
);

  localparam int NS = 5;

  logic [NS-1:0] v;
  logic [NS-1:0] en;

  // per-axis view of the box registers
  logic signed [pbc_pkg::CW-1:0] lo [2];
  logic signed [pbc_pkg::CW-1:0] hi [2];
  logic                          per [2];

  assign lo[0]  = cfg.box_lo_x;
  assign lo[1]  = cfg.box_lo_y;
  assign hi[0]  = cfg.box_hi_x;
  assign hi[1]  = cfg.box_hi_y;
  assign per[0] = cfg.periodic_x;
  assign per[1] = cfg.periodic_y;

  // stage advance: a stage loads when empty or when the next one loads
  assign en[NS-1] = !v[NS-1] || dn_ready;
  for (genvar k = 0; k < NS-1; k++) begin : g_en
    assign en[k] = !v[k] || en[k+1];
  end

  assign up_ready = en[0];
  assign dn_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= up_valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // stage registers
  pbc_pkg::mode_t                s1_mode, s2_mode, s3_mode, s4_mode;
  logic                          s1_last, s2_last, s3_last, s4_last, s5_last;
  logic signed [pbc_pkg::CW-1:0] s1_c [2], s2_c [2], s3_c [2], s4_c [2];
  logic signed [pbc_pkg::CW-1:0] s1_u [2], s2_u [2], s3_u [2], s4_u [2];
  logic signed [pbc_pkg::XW-1:0] s2_len [2];
  logic                          s2_gt [2];
  logic signed [pbc_pkg::XW-1:0] s2_d0 [2], s3_d0 [2];
  logic signed [pbc_pkg::XW-1:0] s3_c1 [2], s3_c1p [2];
  logic signed [pbc_pkg::XW-1:0] s3_dp [2], s3_dm [2];
  logic signed [pbc_pkg::XW-1:0] s3_up [2], s3_um [2], s4_up [2], s4_um [2];
  logic signed [pbc_pkg::XW-1:0] s4_w [2];
  logic signed [pbc_pkg::XW-1:0] s4_m0 [2], s4_mp [2], s4_mm [2];
  logic                          s5_is_cell;
  logic signed [pbc_pkg::CW-1:0] s5_p [2];
  logic signed [pbc_pkg::CW-1:0] s5_res [2];
  logic signed [pbc_pkg::CW-1:0] res_next [2];

  // last stage: pick the image, clip, select by mode
  always_comb begin
    logic signed [pbc_pkg::XW-1:0] b;
    for (int a = 0; a < 2; a++) begin
      if (s4_m0[a] > s4_mp[a]) begin
        b = s4_up[a];
      end else if (s4_m0[a] > s4_mm[a]) begin
        b = s4_um[a];
      end else begin
        b = pbc_pkg::sx(s4_u[a]);
      end
      case (s4_mode)
        pbc_pkg::MODE_WRAP:  res_next[a] = per[a] ? pbc_pkg::sat(s4_w[a]) : s4_c[a];
        pbc_pkg::MODE_BRING: res_next[a] = per[a] ? pbc_pkg::sat(b) : s4_u[a];
        default:             res_next[a] = s4_c[a];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    // stage 1: capture the request
    if (en[0]) begin
      s1_mode <= up_data.mode;
      s1_last <= up_data.last_in;
      s1_c[0] <= up_data.point_x;
      s1_c[1] <= up_data.point_y;
      s1_u[0] <= up_data.moved_x;
      s1_u[1] <= up_data.moved_y;
    end
    // stage 2: box length, upper bound test, offset to reference
    if (en[1]) begin
      s2_mode <= s1_mode;
      s2_last <= s1_last;
      for (int a = 0; a < 2; a++) begin
        s2_c[a]   <= s1_c[a];
        s2_u[a]   <= s1_u[a];
        s2_len[a] <= pbc_pkg::sx(hi[a]) - pbc_pkg::sx(lo[a]);
        s2_gt[a]  <= s1_c[a] > hi[a];
        s2_d0[a]  <= pbc_pkg::sx(s1_u[a]) - pbc_pkg::sx(s1_c[a]);
      end
    end
    // stage 3: first wrap step and both shifted images
    if (en[2]) begin
      s3_mode <= s2_mode;
      s3_last <= s2_last;
      for (int a = 0; a < 2; a++) begin
        s3_c[a]   <= s2_c[a];
        s3_u[a]   <= s2_u[a];
        s3_c1[a]  <= s2_gt[a] ? pbc_pkg::sx(s2_c[a]) - s2_len[a] : pbc_pkg::sx(s2_c[a]);
        s3_c1p[a] <= s2_gt[a] ? pbc_pkg::sx(s2_c[a]) : pbc_pkg::sx(s2_c[a]) + s2_len[a];
        s3_d0[a]  <= s2_d0[a];
        s3_dp[a]  <= s2_d0[a] + s2_len[a];
        s3_dm[a]  <= s2_d0[a] - s2_len[a];
        s3_up[a]  <= pbc_pkg::sx(s2_u[a]) + s2_len[a];
        s3_um[a]  <= pbc_pkg::sx(s2_u[a]) - s2_len[a];
      end
    end
    // stage 4: lower bound wrap step, distances
    if (en[3]) begin
      s4_mode <= s3_mode;
      s4_last <= s3_last;
      for (int a = 0; a < 2; a++) begin
        s4_c[a]  <= s3_c[a];
        s4_u[a]  <= s3_u[a];
        s4_up[a] <= s3_up[a];
        s4_um[a] <= s3_um[a];
        s4_w[a]  <= (s3_c1[a] < pbc_pkg::sx(lo[a])) ? s3_c1p[a] : s3_c1[a];
        s4_m0[a] <= pbc_pkg::mag(s3_d0[a]);
        s4_mp[a] <= pbc_pkg::mag(s3_dp[a]);
        s4_mm[a] <= pbc_pkg::mag(s3_dm[a]);
      end
    end
    // stage 5: result register
    if (en[4]) begin
      s5_is_cell <= (s4_mode == pbc_pkg::MODE_CELL);
      s5_last    <= s4_last;
      for (int a = 0; a < 2; a++) begin
        s5_p[a]   <= s4_c[a];
        s5_res[a] <= res_next[a];
      end
    end
  end

  always_comb begin
    dn_data.is_cell = s5_is_cell;
    dn_data.px      = s5_p[0];
    dn_data.py      = s5_p[1];
    dn_data.res_x   = s5_res[0];
    dn_data.res_y   = s5_res[1];
    dn_data.last    = s5_last;
  end

endmodule

>>> design/pbc_div.sv
// Cell quotient pipeline: offset stage plus one restoring divide step per stage.
`timescale 1ns / 1ps

module pbc_div (
  input  logic          clk,
  input  logic          rst,
  input  pbc_pkg::cfg_t cfg,
  input  logic          up_valid,
  output logic          up_ready,
  input  pbc_pkg::img_t up_data,
  output logic          dn_valid,
  input  logic          dn_ready,
  output pbc_pkg::div_t dn_data
);

  localparam int NS = pbc_pkg::QB + 1;
  localparam int RW = pbc_pkg::RW;
  localparam int XW = pbc_pkg::XW;
  localparam int PW = pbc_pkg::PW;
  localparam int QB = pbc_pkg::QB;

  logic [NS-1:0] v;
  logic [NS-1:0] en;

  logic signed [pbc_pkg::CW-1:0] lo [2];
  assign lo[0] = cfg.box_lo_x;
  assign lo[1] = cfg.box_lo_y;

  // ---- registered values derived from configuration
  logic [pbc_pkg::SIZE_W-1:0] sz_c;
  logic [pbc_pkg::SIZE_W-1:0] sz;
  logic [RW-1:0]              sz_top;
  logic signed [XW-1:0]       len_x;
  logic signed [XW-1:0]       lo_m_sz [2];
  logic signed [PW-1:0]       lo_p_top [2];
  logic [RW-1:0]              nx_num_next;
  logic [RW-1:0]              nx_num;
  logic                       nx_big;
  logic                       nx_zero;

  // zero cell size counts as one
  assign sz_c = (cfg.cell_size == '0) ? pbc_pkg::SIZE_W'(1) : cfg.cell_size;

  // column count numerator: ceiling of box width over size
  assign nx_num_next = (len_x > 0) ? RW'(len_x) + RW'(sz) - RW'(1) : '0;

  always_ff @(posedge clk) begin
    sz     <= sz_c;
    sz_top <= {sz_c, {QB{1'b0}}};
    len_x  <= pbc_pkg::sx(cfg.box_hi_x) - pbc_pkg::sx(cfg.box_lo_x);
    for (int a = 0; a < 2; a++) begin
      lo_m_sz[a]  <= pbc_pkg::sx(lo[a]) - XW'(sz_c);
      lo_p_top[a] <= PW'(lo[a]) + PW'({sz_c, {QB{1'b0}}});
    end
    nx_num  <= nx_num_next;
    nx_big  <= nx_num_next >= sz_top;
    nx_zero <= !(len_x > 0);
  end

  // ---- handshake chain
  assign en[NS-1] = !v[NS-1] || dn_ready;
  for (genvar k = 0; k < NS-1; k++) begin : g_en
    assign en[k] = !v[k] || en[k+1];
  end

  assign up_ready = en[0];
  assign dn_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= up_valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // ---- datapath registers; lanes are column, row, column count
  pbc_pkg::img_t  side [NS];
  logic [1:0]     negq [NS];
  logic [1:0]     big  [NS];
  logic [RW-1:0]  rem  [NS][3];
  logic [QB-1:0]  q    [NS][3];
  logic [RW-1:0]  dsh  [NS-1];

  logic signed [pbc_pkg::CW-1:0] p [2];
  logic signed [XW-1:0]          dx [2];
  logic                          neg [2];

  assign p[0] = up_data.px;
  assign p[1] = up_data.py;

  // divisor shifted to each step's quotient bit
  always_comb begin
    for (int k = 1; k < NS; k++) begin
      dsh[k-1] = sz_top >> k;
    end
  end

  // offsets from the lower corner
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      dx[a]  = pbc_pkg::sx(p[a]) - pbc_pkg::sx(lo[a]);
      neg[a] = p[a] < lo[a];
    end
  end

  always_ff @(posedge clk) begin
    // offset stage: negative cells, overflow above the quotient range
    if (en[0]) begin
      side[0] <= up_data;
      for (int a = 0; a < 2; a++) begin
        rem[0][a] <= neg[a] ? '0 : RW'(dx[a]);
        negq[0][a] <= pbc_pkg::sx(p[a]) <= lo_m_sz[a];
        big[0][a]  <= PW'(p[a]) >= lo_p_top[a];
        q[0][a]    <= '0;
      end
      rem[0][2] <= nx_num;
      q[0][2]   <= '0;
    end
    // one quotient bit per stage, MSB first
    for (int k = 1; k < NS; k++) begin
      if (en[k]) begin
        side[k] <= side[k-1];
        negq[k] <= negq[k-1];
        big[k]  <= big[k-1];
        for (int l = 0; l < 3; l++) begin
          if (rem[k-1][l] >= dsh[k-1]) begin
            rem[k][l] <= rem[k-1][l] - dsh[k-1];
            q[k][l]   <= {q[k-1][l][QB-2:0], 1'b1};
          end else begin
            rem[k][l] <= rem[k-1][l];
            q[k][l]   <= {q[k-1][l][QB-2:0], 1'b0};
          end
        end
      end
    end
  end

  always_comb begin
    dn_data.is_cell = side[NS-1].is_cell;
    dn_data.res_x   = side[NS-1].res_x;
    dn_data.res_y   = side[NS-1].res_y;
    dn_data.last    = side[NS-1].last;
    dn_data.col_neg = negq[NS-1][0];
    dn_data.row_neg = negq[NS-1][1];
    dn_data.col_big = big[NS-1][0];
    dn_data.row_big = big[NS-1][1];
    dn_data.col_q   = q[NS-1][0];
    dn_data.row_q   = q[NS-1][1];
    dn_data.nx_q    = q[NS-1][2];
    dn_data.nx_big  = nx_big;
    dn_data.nx_zero = nx_zero;
  end

endmodule

>>> design/pbc_grid.sv
// Grid fit and flat index: clamp cell coordinates, then col * rows + row.
`timescale 1ns / 1ps

module pbc_grid (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [pbc_pkg::CNT_W-1:0]   cells_y,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  pbc_pkg::div_t               up_data,
  output logic                        dn_valid,
  input  logic                        dn_ready,
  output pbc_pkg::rsp_t               dn_data
);

  localparam int NS = 2;
  localparam int QB = pbc_pkg::QB;
  localparam int CELL_W = pbc_pkg::CELL_W;
  localparam int IDX_W = pbc_pkg::IDX_W;

  logic [NS-1:0] v;
  logic [NS-1:0] en;

  assign en[NS-1] = !v[NS-1] || dn_ready;
  assign en[0]    = !v[0] || en[1];
  assign up_ready = en[0];
  assign dn_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= up_valid;
      if (en[1]) v[1] <= v[0];
    end
  end

  // grid extents and clamped coordinates
  logic [QB-1:0]     ncol;
  logic [QB-1:0]     nrow;
  logic [CELL_W-1:0] col_c;
  logic [CELL_W-1:0] row_c;
  logic              out_c;

  always_comb begin
    if (up_data.nx_zero) begin
      ncol = QB'(1);
    end else if (up_data.nx_big || up_data.nx_q > pbc_pkg::MAX_Q) begin
      ncol = pbc_pkg::MAX_Q;
    end else begin
      ncol = up_data.nx_q;
    end

    if (cells_y == '0) begin
      nrow = QB'(1);
    end else if (QB'(cells_y) > pbc_pkg::MAX_Q) begin
      nrow = pbc_pkg::MAX_Q;
    end else begin
      nrow = QB'(cells_y);
    end

    out_c = 1'b0;
    if (up_data.col_neg) begin
      col_c = '0;
      out_c = 1'b1;
    end else if (up_data.col_big || up_data.col_q >= ncol) begin
      col_c = CELL_W'(ncol - QB'(1));
      out_c = 1'b1;
    end else begin
      col_c = CELL_W'(up_data.col_q);
    end

    if (up_data.row_neg) begin
      row_c = '0;
      out_c = 1'b1;
    end else if (up_data.row_big || up_data.row_q >= nrow) begin
      row_c = CELL_W'(nrow - QB'(1));
      out_c = 1'b1;
    end else begin
      row_c = CELL_W'(up_data.row_q);
    end
  end

  logic                          g1_is_cell;
  logic                          g1_last;
  logic signed [pbc_pkg::CW-1:0] g1_res_x;
  logic signed [pbc_pkg::CW-1:0] g1_res_y;
  logic [CELL_W-1:0]             g1_col;
  logic [CELL_W-1:0]             g1_row;
  logic                          g1_out;
  logic [QB-1:0]                 g1_nrow;
  logic [IDX_W-1:0]              idx_next;

  assign idx_next = IDX_W'(g1_col) * IDX_W'(g1_nrow) + IDX_W'(g1_row);

  always_ff @(posedge clk) begin
    // stage 1: clamp into the grid
    if (en[0]) begin
      g1_is_cell <= up_data.is_cell;
      g1_last    <= up_data.last;
      g1_res_x   <= up_data.res_x;
      g1_res_y   <= up_data.res_y;
      g1_col     <= col_c;
      g1_row     <= row_c;
      g1_out     <= out_c;
      g1_nrow    <= nrow;
    end
    // stage 2: flat index, cell fields only in cell mode
    if (en[1]) begin
      dn_data.res_x       <= g1_res_x;
      dn_data.res_y       <= g1_res_y;
      dn_data.last_out    <= g1_last;
      dn_data.cell_col    <= g1_is_cell ? g1_col : '0;
      dn_data.cell_row    <= g1_is_cell ? g1_row : '0;
      dn_data.cell_index  <= g1_is_cell ? idx_next : '0;
      dn_data.out_of_grid <= g1_is_cell && g1_out;
    end
  end

endmodule

>>> design/periodic_box_cell_mapper.sv
// Top level: configuration registers and the image, divide and grid pipelines.
`timescale 1ns / 1ps

// Channel   Signals                             Payload
// request   req_valid / req_ready / req_data    pbc_pkg::req_t
// result    rsp_valid / rsp_ready / rsp_data    pbc_pkg::rsp_t
// config    cfg_we / cfg_index / cfg_data       one register per write
//
// One request per cycle sustained while rsp_ready is high. A request passes
// 19 register stages (5 image, 12 divider, 2 grid) on its way to the result.
// The divider takes one quotient bit per stage, which sets the depth.
// rst is synchronous and clears the configuration registers and all stage valid bits.
// Every stage holds its item while the one after it is full and stalled, so
// bubbles close up and requests are taken while a result waits.

module periodic_box_cell_mapper (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  pbc_pkg::req_t                 req_data,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output pbc_pkg::rsp_t                 rsp_data,
  input  logic                          cfg_we,
  input  logic [pbc_pkg::CFG_AW-1:0]    cfg_index,
  input  logic [pbc_pkg::CFG_DW-1:0]    cfg_data
);

  pbc_pkg::cfg_t cfg;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.box_lo_x   <= '0;
      cfg.box_lo_y   <= '0;
      cfg.box_hi_x   <= pbc_pkg::CW'(65536);
      cfg.box_hi_y   <= pbc_pkg::CW'(65536);
      cfg.cell_size  <= pbc_pkg::SIZE_W'(65536);
      cfg.periodic_x <= 1'b0;
      cfg.periodic_y <= 1'b0;
      cfg.cells_y    <= pbc_pkg::CNT_W'(1);
    end else if (cfg_we) begin
      case (pbc_pkg::cfg_idx_t'(cfg_index))
        pbc_pkg::CFG_BOX_LO_X:   cfg.box_lo_x   <= cfg_data[pbc_pkg::CW-1:0];
        pbc_pkg::CFG_BOX_LO_Y:   cfg.box_lo_y   <= cfg_data[pbc_pkg::CW-1:0];
        pbc_pkg::CFG_BOX_HI_X:   cfg.box_hi_x   <= cfg_data[pbc_pkg::CW-1:0];
        pbc_pkg::CFG_BOX_HI_Y:   cfg.box_hi_y   <= cfg_data[pbc_pkg::CW-1:0];
        pbc_pkg::CFG_CELL_SIZE:  cfg.cell_size  <= cfg_data[pbc_pkg::SIZE_W-1:0];
        pbc_pkg::CFG_PERIODIC_X: cfg.periodic_x <= cfg_data[0];
        pbc_pkg::CFG_PERIODIC_Y: cfg.periodic_y <= cfg_data[0];
        pbc_pkg::CFG_CELLS_Y:    cfg.cells_y    <= cfg_data[pbc_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // image -> divider -> grid
  logic          img_valid, img_ready;
  pbc_pkg::img_t img_data;
  logic          div_valid, div_ready;
  pbc_pkg::div_t div_data;

  pbc_image u_image (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_valid (req_valid),
    .up_ready (req_ready),
    .up_data  (req_data),
    .dn_valid (img_valid),
    .dn_ready (img_ready),
    .dn_data  (img_data)
  );

  pbc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_valid (img_valid),
    .up_ready (img_ready),
    .up_data  (img_data),
    .dn_valid (div_valid),
    .dn_ready (div_ready),
    .dn_data  (div_data)
  );

  pbc_grid u_grid (
    .clk      (clk),
    .rst      (rst),
    .cells_y  (cfg.cells_y),
    .up_valid (div_valid),
    .up_ready (div_ready),
    .up_data  (div_data),
    .dn_valid (rsp_valid),
    .dn_ready (rsp_ready),
    .dn_data  (rsp_data)
  );

endmodule
